// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mbrr_pkg.sv =====
// ---------------------------------------------------------------------------
// mbrr_pkg
// Shared constants, codes and the CRC-16/Modbus byte step.
// ---------------------------------------------------------------------------
package mbrr_pkg;

  localparam int SIL_W  = 10;
  localparam int ADDR_W = 16;
  localparam int RADR_W = 8;
  localparam int VAL_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = 3;

  localparam logic [SIL_W-1:0]  SIL_RST  = 10'd100;
  localparam logic [ADDR_W-1:0] ADDR_RST = 16'd107;
  localparam logic [RADR_W-1:0] RADR_RST = 8'd1;
  localparam logic [VAL_W-1:0]  VAL_RST  = 16'd170;

  localparam logic [7:0]       FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]       REPLY_BYTE_COUNT  = 8'h02;
  localparam logic [15:0]      CRC_INIT          = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY          = 16'hA001;
  localparam logic [CNT_W-1:0] FRAME_LEN         = 4'd8;
  localparam logic [CNT_W-1:0] COUNT_SAT         = 4'd9;

  // input word kind
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    REG_SILENCE  = 2'd0,
    REG_ADDRESS  = 2'd1,
    REG_REPLY_AD = 2'd2,
    REG_VALUE    = 2'd3
  } cfg_idx_t;

  // byte positions in the request
  localparam logic [CNT_W-1:0] POS_FUNC   = 4'd1;
  localparam logic [CNT_W-1:0] POS_ADDR_H = 4'd2;
  localparam logic [CNT_W-1:0] POS_ADDR_L = 4'd3;

  // byte positions in the reply
  localparam logic [IDX_W-1:0] TX_ADDR   = 3'd0;
  localparam logic [IDX_W-1:0] TX_FUNC   = 3'd1;
  localparam logic [IDX_W-1:0] TX_COUNT  = 3'd2;
  localparam logic [IDX_W-1:0] TX_VAL_H  = 3'd3;
  localparam logic [IDX_W-1:0] TX_VAL_L  = 3'd4;
  localparam logic [IDX_W-1:0] TX_CRC_L  = 3'd5;
  localparam logic [IDX_W-1:0] TX_CRC_H  = 3'd6;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrr_frame.sv =====
// ---------------------------------------------------------------------------
// mbrr_frame
// Input register and request frame tracker; flags a qualifying frame end.
// ---------------------------------------------------------------------------
module mbrr_frame import mbrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tuser,   // [0] opcode
  input  logic [SIL_W-1:0]  silence_ticks,
  input  logic [ADDR_W-1:0] register_address,
  output logic              hit_valid,
  input  logic              hit_ready
);

  logic             stg_v_r;
  logic             stg_op_r;
  logic [7:0]       stg_byte_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       addr_h_r, addr_h_nxt;
  logic [7:0]       addr_l_r, addr_l_nxt;
  logic [SIL_W-1:0] idle_r, idle_nxt;
  logic             started_r, started_nxt;

  logic [SIL_W:0]   idle_inc;
  logic             frame_end;
  logic             hit;
  logic             advance;

  assign idle_inc  = {1'b0, idle_r} + {{SIL_W{1'b0}}, 1'b1};
  assign frame_end = (stg_op_r == OP_TICK) && started_r && (idle_inc > {1'b0, silence_ticks});
  assign hit       = frame_end && (count_r == FRAME_LEN) && (func_r == FUNC_READ_HOLDING)
                     && ({addr_h_r, addr_l_r} == register_address);

  assign hit_valid = stg_v_r && hit;
  assign advance   = stg_v_r && (!hit || hit_ready);
  assign in_tready = !stg_v_r || advance;

  always_comb begin
    count_nxt   = count_r;
    func_nxt    = func_r;
    addr_h_nxt  = addr_h_r;
    addr_l_nxt  = addr_l_r;
    idle_nxt    = idle_r;
    started_nxt = started_r;
    if (stg_op_r == OP_BYTE) begin
      case (count_r)
        POS_FUNC:   func_nxt   = stg_byte_r;
        POS_ADDR_H: addr_h_nxt = stg_byte_r;
        POS_ADDR_L: addr_l_nxt = stg_byte_r;
        default: ;
      endcase
      if (count_r < COUNT_SAT) count_nxt = count_r + 4'd1;
      idle_nxt    = '0;
      started_nxt = 1'b1;
    end else if (frame_end) begin
      count_nxt   = '0;
      func_nxt    = '0;
      addr_h_nxt  = '0;
      addr_l_nxt  = '0;
      idle_nxt    = '0;
      started_nxt = 1'b0;
    end else if (started_r) begin
      idle_nxt = idle_inc[SIL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r   <= 1'b0;
      count_r   <= '0;
      func_r    <= '0;
      addr_h_r  <= '0;
      addr_l_r  <= '0;
      idle_r    <= '0;
      started_r <= 1'b0;
    end else begin
      if (in_tready) stg_v_r <= in_tvalid;
      if (advance) begin
        count_r   <= count_nxt;
        func_r    <= func_nxt;
        addr_h_r  <= addr_h_nxt;
        addr_l_r  <= addr_l_nxt;
        idle_r    <= idle_nxt;
        started_r <= started_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_op_r   <= in_tuser;
      stg_byte_r <= in_tdata;
    end
  end

endmodule

// ===== rtl/mbrr_reply.sv =====
// ---------------------------------------------------------------------------
// mbrr_reply
// Reply sequencer: sends the seven reply words, CRC built as bytes go out.
// ---------------------------------------------------------------------------
module mbrr_reply import mbrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hit_valid,
  output logic              hit_ready,
  input  logic [RADR_W-1:0] reply_address,
  input  logic [VAL_W-1:0]  register_value,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic              busy_r;
  logic [IDX_W-1:0]  idx_r;
  logic [15:0]       crc_r;
  logic [RADR_W-1:0] radr_r;
  logic [VAL_W-1:0]  val_r;
  logic              fire;

  assign hit_ready  = !busy_r;
  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == TX_CRC_H);
  assign fire       = busy_r && out_tready;

  always_comb begin
    case (idx_r)
      TX_ADDR:  out_tdata = radr_r;
      TX_FUNC:  out_tdata = FUNC_READ_HOLDING;
      TX_COUNT: out_tdata = REPLY_BYTE_COUNT;
      TX_VAL_H: out_tdata = val_r[15:8];
      TX_VAL_L: out_tdata = val_r[7:0];
      TX_CRC_L: out_tdata = crc_r[7:0];
      default:  out_tdata = crc_r[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (hit_valid && hit_ready) begin
      busy_r <= 1'b1;
      idx_r  <= TX_ADDR;
    end else if (fire) begin
      idx_r <= idx_r + 3'd1;
      if (out_tlast) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_valid && hit_ready) begin
      radr_r <= reply_address;
      val_r  <= register_value;
      crc_r  <= CRC_INIT;
    end else if (fire && (idx_r < TX_CRC_L)) begin
      crc_r <= crc_step(crc_r, out_tdata);
    end
  end

endmodule

// ===== rtl/modbus_rtu_register_read_responder_top.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU read-holding-register responder
// Answers a one-register read request with a seven-byte reply.
// ---------------------------------------------------------------------------
// Input words are received bytes (tuser 0) or millisecond ticks (tuser 1);
// each is registered when accepted, and one may follow in every cycle
// unless the input is stalled as below. A frame ends on the tick that
// takes the silence count past silence_ticks; if it held exactly eight
// bytes with function 0x03 and the configured address, the reply goes
// out as seven words, one per cycle while out_tready is high, with tlast
// on the CRC high byte. The reply sequencer holds one reply at a time: a
// second qualifying frame end stalls input until that reply is sent.
module modbus_rtu_register_read_responder_top import mbrr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] tx_byte
  output logic             out_tlast,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [SIL_W-1:0]  silence_r;
  logic [ADDR_W-1:0] reg_addr_r;
  logic [RADR_W-1:0] reply_adr_r;
  logic [VAL_W-1:0]  reg_val_r;
  logic              hit_valid;
  logic              hit_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r   <= SIL_RST;
      reg_addr_r  <= ADDR_RST;
      reply_adr_r <= RADR_RST;
      reg_val_r   <= VAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SILENCE:  silence_r   <= cfg_wdata[SIL_W-1:0];
        REG_ADDRESS:  reg_addr_r  <= cfg_wdata[ADDR_W-1:0];
        REG_REPLY_AD: reply_adr_r <= cfg_wdata[RADR_W-1:0];
        REG_VALUE:    reg_val_r   <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  mbrr_frame u_frame (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .silence_ticks    (silence_r),
    .register_address (reg_addr_r),
    .hit_valid        (hit_valid),
    .hit_ready        (hit_ready)
  );

  mbrr_reply u_reply (
    .clk            (clk),
    .rst_n          (rst_n),
    .hit_valid      (hit_valid),
    .hit_ready      (hit_ready),
    .reply_address  (reply_adr_r),
    .register_value (reg_val_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

endmodule

// ===== rtl/mbrr_checker.sv =====
// ---------------------------------------------------------------------------
// mbrr_checker
// Port-level checks on the responder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mbrr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled reply word holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // after reset: input open, no reply pending
  `ASSERT_IMP(a_rst_clear, clk, rst_n, $past(!rst_n), in_tready && !out_tvalid)

  // a finished reply is never followed straight away by another word
  `ASSERT_NXT(a_tlast_gap, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)

endmodule

bind modbus_rtu_register_read_responder_top mbrr_checker u_chk (.*);
